>>> rtl/core/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

	// list size and derived widths
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// word field widths
	localparam int CMD_W  = 2;
	localparam int POS_W  = 7;
	localparam int DATA_W = 32;
	localparam int LEN_W  = 7;

	// command codes on the request channel
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd2;

	// classified operations handed from front to back
	localparam logic [1:0] OP_NOP = 2'd0;
	localparam logic [1:0] OP_INS = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;
	localparam logic [1:0] OP_LOC = 2'd3;

	// op queue depth
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0]               kind;
		logic [ADDR_W-1:0]        idx;     // 0-based slot for insert/delete
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]         count;   // length before the op
		logic [CNT_W-1:0]         new_len; // length after the op
	} pls_op_t;

endpackage

`default_nettype wire

>>> rtl/core/pls_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pls_in_if;
	import pls_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, cmd, position, value, input ready);
	modport sink   (input valid, cmd, position, value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pls_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pls_out_if;
	import pls_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic signed [DATA_W-1:0] removed_value;
	logic [POS_W-1:0]         found_position;
	logic [LEN_W-1:0]         list_length;

	modport source (output valid, ok, removed_value, found_position, list_length, input ready);
	modport sink   (input valid, ok, removed_value, found_position, list_length, output ready);
endinterface

`default_nettype wire

>>> rtl/core/positional_list_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to 64 signed 32-bit entries, empty after reset. Each request
// word (insert, delete or locate) yields exactly one response word carrying ok, the
// removed value, the found position and the new length. Requests are range-checked
// on entry and queued two deep, so the request side can run ahead of a busy list.
// All list work goes through one memory with a registered read port and a write
// port, moving one entry per cycle. Insert at position p in a list of n shifts the
// entries from position p to n up by one slot and then writes the new entry; delete
// reads from position p to n, keeping the removed value and shifting the rest down;
// locate reads from the head until the first match or the end of the list. A rejected
// or unknown command, or a locate on an empty list, reads no entry. A stalled response
// holds the list engine in its final state. No memory clearing pass is needed after reset.
module positional_list_store (
	input  wire logic clk,
	input  wire logic arst_n,
	pls_in_if.sink    req,
	pls_out_if.source rsp
);
	import pls_pkg::*;

	pls_op_t front_op;
	pls_op_t back_op;
	logic    push;
	logic    full;
	logic    q_valid;
	logic    q_pop;

	pls_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.op     (front_op),
		.push   (push),
		.full   (full)
	);

	pls_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (front_op),
		.full    (full),
		.valid   (q_valid),
		.pop     (q_pop),
		.pop_op  (back_op)
	);

	pls_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (back_op),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

>>> rtl/core/pls_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	pls_in_if.sink          req,
	output pls_pkg::pls_op_t op,
	output logic            push,
	input  wire logic       full
);
	import pls_pkg::*;

	logic [CNT_W-1:0] count_q;  // length as seen after every accepted word
	logic             ins_ok;
	logic             del_ok;

	assign req.ready = !full;
	assign push      = req.valid && !full;

	// range checks against the running length
	assign ins_ok = (32'(req.position) >= 32'd1) &&
	                (32'(req.position) <= 32'(count_q) + 32'd1) &&
	                (32'(count_q) < CAPACITY);
	assign del_ok = (32'(req.position) >= 32'd1) &&
	                (32'(req.position) <= 32'(count_q));

	// classify the word
	always_comb begin
		op.idx     = ADDR_W'(32'(req.position) - 32'd1);
		op.value   = req.value;
		op.count   = count_q;
		op.new_len = count_q;
		op.kind    = OP_NOP;
		unique case (req.cmd)
			CMD_INSERT: begin
				if (ins_ok) begin
					op.kind    = OP_INS;
					op.new_len = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (del_ok) begin
					op.kind    = OP_DEL;
					op.new_len = count_q - CNT_W'(1);
				end
			end
			CMD_LOCATE: op.kind = OP_LOC;
			default:    op.kind = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= op.new_len;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("front length count beyond capacity");

endmodule

`default_nettype wire

>>> rtl/core/pls_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire pls_pkg::pls_op_t push_op,
	output logic                  full,
	output logic                  valid,
	input  wire logic             pop,
	output pls_pkg::pls_op_t      pop_op
);
	import pls_pkg::*;

	pls_op_t           ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full   = (32'(cnt_q) == QDEPTH);
	assign valid  = (cnt_q != '0);
	assign do_pop = pop && valid;
	assign pop_op = ent_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (32'(wr_q) == QDEPTH - 1) ? '0 : wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (32'(rd_q) == QDEPTH - 1) ? '0 : rd_q + QPTR_W'(1);
			end
			if ((push && !full) && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!(push && !full) && do_pop) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wr_q] <= push_op;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= QDEPTH)
		else $error("op queue fill level beyond depth");

endmodule

`default_nettype wire

>>> rtl/core/pls_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire pls_pkg::pls_op_t q_op,
	output logic                  q_pop,
	pls_out_if.source             rsp
);
	import pls_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RUN  = 2'd1;
	localparam logic [1:0] B_FIN  = 2'd2;

	logic [1:0]               state_q;
	pls_op_t                  op_q;
	logic [CNT_W-1:0]         rem_q;      // reads still to issue
	logic [ADDR_W-1:0]        rd_addr_q;
	logic                     rd_vld_s1;
	logic [ADDR_W-1:0]        rd_addr_s1;
	logic signed [DATA_W-1:0] rd_data_s1;
	logic                     found_q;
	logic [POS_W-1:0]         found_pos_q;
	logic signed [DATA_W-1:0] removed_q;

	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic                     wen;
	logic [ADDR_W-1:0]        waddr;
	logic signed [DATA_W-1:0] wdata;
	logic                     ren;
	logic                     hit;
	logic                     run_done;
	logic                     out_free;

	logic                     out_vld_q;
	logic                     out_ok_q;
	logic signed [DATA_W-1:0] out_removed_q;
	logic [POS_W-1:0]         out_found_q;
	logic [LEN_W-1:0]         out_len_q;

	assign q_pop    = (state_q == B_IDLE) && q_valid;
	assign hit      = rd_vld_s1 && (op_q.kind == OP_LOC) && (rd_data_s1 == op_q.value);
	assign ren      = (state_q == B_RUN) && (rem_q != '0) && !found_q && !hit;
	assign run_done = (state_q == B_RUN) && !rd_vld_s1 && ((rem_q == '0) || found_q);
	assign out_free = !out_vld_q || rsp.ready;

	// single write port: shifted entries while running, new entry at the end of an insert
	always_comb begin
		wen   = 1'b0;
		waddr = rd_addr_s1;
		wdata = rd_data_s1;
		if (state_q == B_FIN) begin
			wen   = (op_q.kind == OP_INS);
			waddr = op_q.idx;
			wdata = op_q.value;
		end else if (rd_vld_s1) begin
			if (op_q.kind == OP_INS) begin
				wen   = 1'b1;
				waddr = rd_addr_s1 + ADDR_W'(1);
			end else if (op_q.kind == OP_DEL && rd_addr_s1 != op_q.idx) begin
				wen   = 1'b1;
				waddr = rd_addr_s1 - ADDR_W'(1);
			end
		end
	end

	// list storage, registered read
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			rem_q     <= '0;
		end else begin
			rd_vld_s1 <= ren;
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						found_q <= 1'b0;
						state_q <= B_RUN;
						case (q_op.kind)
							OP_INS:  rem_q <= q_op.count - CNT_W'(q_op.idx);
							OP_DEL:  rem_q <= q_op.count - CNT_W'(q_op.idx);
							OP_LOC:  rem_q <= q_op.count;
							default: rem_q <= '0;
						endcase
					end
				end
				B_RUN: begin
					if (ren) begin
						rem_q <= rem_q - CNT_W'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
					end
					if (run_done) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// operation payload, read address walk, captured results
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
			case (q_op.kind)
				OP_INS:  rd_addr_q <= ADDR_W'(q_op.count - CNT_W'(1));
				OP_DEL:  rd_addr_q <= q_op.idx;
				default: rd_addr_q <= '0;
			endcase
		end else if (ren) begin
			rd_addr_q <= (op_q.kind == OP_INS) ? rd_addr_q - ADDR_W'(1)
			                                   : rd_addr_q + ADDR_W'(1);
		end
		if (ren) begin
			rd_addr_s1 <= rd_addr_q;
		end
		if (rd_vld_s1 && op_q.kind == OP_DEL && rd_addr_s1 == op_q.idx) begin
			removed_q <= rd_data_s1;
		end
		if (hit && !found_q) begin
			found_pos_q <= POS_W'(CNT_W'(rd_addr_s1) + CNT_W'(1));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == B_FIN && out_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_FIN && out_free) begin
			out_ok_q      <= (op_q.kind == OP_INS) || (op_q.kind == OP_DEL) ||
			                 ((op_q.kind == OP_LOC) && found_q);
			out_removed_q <= (op_q.kind == OP_DEL) ? removed_q : '0;
			out_found_q   <= ((op_q.kind == OP_LOC) && found_q) ? found_pos_q : '0;
			out_len_q     <= LEN_W'(op_q.new_len);
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.ok             = out_ok_q;
	assign rsp.removed_value  = out_removed_q;
	assign rsp.found_position = out_found_q;
	assign rsp.list_length    = out_len_q;

	a_read_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		ren |-> (CNT_W'(rd_addr_q) < op_q.count))
		else $error("read of a slot beyond the list length");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |=> (state_q == B_FIN))
		else $error("sequencer did not finish after the last read");

	a_no_write_read_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wen && ren) |-> (waddr != rd_addr_q))
		else $error("shift write hit the slot being read");

endmodule

`default_nettype wire
